// File: sv/bagu_pkg.sv
// shared types, constants and tile-code table for the autotile grid update block
`timescale 1ns / 1ps
package bagu_pkg;

	// default grid storage size
	localparam int unsigned MAX_COLUMNS_DEF = 64;
	localparam int unsigned MAX_ROWS_DEF    = 64;

	// configuration port
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd2;
	localparam logic [CFG_W-1:0] COLS_RST = 7'd32;
	localparam logic [CFG_W-1:0] ROWS_RST = 7'd18;

	// stored cell word: occupied flag over a 6-bit code
	localparam int CELL_W = 7;
	localparam int OCC    = 6;
	localparam logic [5:0] CODE_ISOLATED = 6'd47;

	typedef struct packed {
		logic       action;
		logic [5:0] cell_column;
		logic [5:0] cell_row;
	} item_t;

	typedef struct packed {
		logic       status;
		logic [5:0] out_column;
		logic [5:0] out_row;
		logic       cell_empty;
		logic [5:0] tile_code;
		logic       last_result;
	} result_t;

	// gated 8-neighbour masks in tile-code order (code = place + 1)
	localparam int NUM_BLOB = 46;
	localparam logic [7:0] BLOB_MASKS [NUM_BLOB] = '{
		8'd2,   8'd8,   8'd10,  8'd11,  8'd16,  8'd18,  8'd22,  8'd24,
		8'd26,  8'd27,  8'd30,  8'd31,  8'd64,  8'd66,  8'd72,  8'd74,
		8'd75,  8'd80,  8'd82,  8'd86,  8'd88,  8'd90,  8'd91,  8'd94,
		8'd95,  8'd104, 8'd106, 8'd107, 8'd120, 8'd122, 8'd123, 8'd126,
		8'd127, 8'd208, 8'd210, 8'd214, 8'd216, 8'd218, 8'd219, 8'd222,
		8'd223, 8'd248, 8'd250, 8'd251, 8'd254, 8'd255
	};

	// map a gated mask to its blob tile code; an empty mask gives the isolated tile
	function automatic logic [5:0] blob_code(input logic [7:0] mask);
		logic [5:0] code;
		code = CODE_ISOLATED;
		for (int k = 0; k < NUM_BLOB; k++) begin
			if (BLOB_MASKS[k] == mask) begin
				code = 6'(k + 1);
			end
		end
		return code;
	endfunction

	// sequencer step addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_CLEAR  = 4'd0;
	localparam logic [STEP_W-1:0] ST_IDLE   = 4'd1;
	localparam logic [STEP_W-1:0] ST_CHECK  = 4'd2;
	localparam logic [STEP_W-1:0] ST_CENTER = 4'd3;
	localparam logic [STEP_W-1:0] ST_READ   = 4'd4;
	localparam logic [STEP_W-1:0] ST_DRAIN  = 4'd5;
	localparam logic [STEP_W-1:0] ST_EMIT   = 4'd6;
	localparam logic [STEP_W-1:0] ST_RETURN = 4'd7;
	localparam logic [STEP_W-1:0] ST_ERROR  = 4'd8;

	// jump conditions
	typedef enum logic [2:0] {
		JC_NEXT,
		JC_ALWAYS,
		JC_NOT_START,
		JC_ERR,
		JC_CNT_MORE,
		JC_CLR_MORE
	} jcond_t;

	// one control word
	typedef struct packed {
		logic              clr_wr;
		logic              idle;
		logic              ctr_clr;
		logic              center_wr;
		logic              rd_issue;
		logic              emit;
		logic              err_emit;
		logic [2:0]        span_last;
		jcond_t            jc;
		logic [STEP_W-1:0] target;
	} uop_t;

	localparam uop_t UOP_NOP = '{
		clr_wr:    1'b0,
		idle:      1'b0,
		ctr_clr:   1'b0,
		center_wr: 1'b0,
		rd_issue:  1'b0,
		emit:      1'b0,
		err_emit:  1'b0,
		span_last: 3'd0,
		jc:        JC_NEXT,
		target:    ST_IDLE
	};

	// datapath status seen by the sequencer
	typedef struct packed {
		logic start;
		logic err;
		logic cnt_more;
		logic clr_more;
	} seq_flags_t;

endpackage

// File: sv/bagu_ram.sv
// generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module bagu_ram #(
	parameter int WIDTH  = 7,
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: sv/bagu_seq.sv
// microcode sequencer: control store, step counter and conditional jumps
`timescale 1ns / 1ps
module bagu_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  bagu_pkg::seq_flags_t flags,
	output bagu_pkg::uop_t    uop
);
	import bagu_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic              take;

	// control store
	always_comb begin
		uop = UOP_NOP;
		unique case (step_q)
			ST_CLEAR: begin
				uop.clr_wr = 1'b1;
				uop.jc     = JC_CLR_MORE;
				uop.target = ST_CLEAR;
			end
			ST_IDLE: begin
				uop.idle    = 1'b1;
				uop.ctr_clr = 1'b1;
				uop.jc      = JC_NOT_START;
				uop.target  = ST_IDLE;
			end
			ST_CHECK: begin
				uop.jc     = JC_ERR;
				uop.target = ST_ERROR;
			end
			ST_CENTER: begin
				uop.center_wr = 1'b1;
				uop.ctr_clr   = 1'b1;
			end
			ST_READ: begin
				uop.rd_issue  = 1'b1;
				uop.span_last = 3'd4;
				uop.jc        = JC_CNT_MORE;
				uop.target    = ST_READ;
			end
			ST_DRAIN: begin
				uop.ctr_clr = 1'b1;
			end
			ST_EMIT: begin
				uop.emit      = 1'b1;
				uop.span_last = 3'd2;
				uop.jc        = JC_CNT_MORE;
				uop.target    = ST_EMIT;
			end
			ST_RETURN: begin
				uop.jc     = JC_ALWAYS;
				uop.target = ST_IDLE;
			end
			ST_ERROR: begin
				uop.err_emit = 1'b1;
				uop.jc       = JC_ALWAYS;
				uop.target   = ST_IDLE;
			end
			default: begin
				uop.jc     = JC_ALWAYS;
				uop.target = ST_IDLE;
			end
		endcase
	end

	// jump condition select
	always_comb begin
		unique case (uop.jc)
			JC_NEXT:      take = 1'b0;
			JC_ALWAYS:    take = 1'b1;
			JC_NOT_START: take = !flags.start;
			JC_ERR:       take = flags.err;
			JC_CNT_MORE:  take = flags.cnt_more;
			JC_CLR_MORE:  take = flags.clr_more;
			default:      take = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CLEAR;
		end else begin
			step_q <= take ? uop.target : step_q + 1'b1;
		end
	end

endmodule

// File: sv/bitmask_autotile_grid_update.sv
// top level: tile map store, 5x5 window datapath and result register
`timescale 1ns / 1ps
// After reset the block clears every cell of its map, one cell per cycle, with busy high;
// configuration writes are taken throughout.
// An in-range edit keeps busy high while it writes the edited cell, makes 25 single-port reads
// of the 5x5 window and then scans the 3x3 neighbourhood; results appear during that scan.
// An out-of-range edit gives its single error result.
// Results are single-cycle strobes and never wait on the receiver.
module bitmask_autotile_grid_update #(
	parameter int MAX_COLUMNS = bagu_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = bagu_pkg::MAX_ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  bagu_pkg::item_t                item,
	output logic                           result_valid,
	output bagu_pkg::result_t              result,
	input  logic                           cfg_we,
	input  logic [bagu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bagu_pkg::CFG_W-1:0]     cfg_wdata
);
	import bagu_pkg::*;

	localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);

	// map a cell to its store address
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] r, input logic [6:0] c);
		return ADDR_W'(32'(r) * MAX_COLUMNS + 32'(c));
	endfunction

	uop_t       uop;
	seq_flags_t flags;

	logic             mode_q;
	logic [CFG_W-1:0] cols_q;
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] eff_cols;
	logic [CFG_W-1:0] eff_rows;

	item_t item_q;
	logic  err_q;
	logic  accept;

	logic [ADDR_W-1:0] clr_addr_q;
	logic [2:0]        r_q;
	logic [2:0]        c_q;
	logic              cnt_last;

	logic              rd_v_s1;
	logic              rd_inb_s1;
	logic [2:0]        rd_r_s1;
	logic [2:0]        rd_c_s1;
	logic [7:0]        rd_row;
	logic [7:0]        rd_col;
	logic              rd_inb;
	logic [4:0][4:0]   win_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [CELL_W-1:0] mem_rdata;

	logic [2:0][2:0]   nb;
	logic [3:0]        edge_mask;
	logic [7:0]        blob_mask;
	logic [5:0]        code;
	logic              centre;
	logic              occ;
	logic [8:0]        elig;
	logic [3:0]        pos;
	logic              later;
	logic [7:0]        em_row;
	logic [7:0]        em_col;

	result_t result_q;
	logic    result_valid_q;

	bagu_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uop    (uop)
	);

	bagu_ram #(
		.WIDTH  (CELL_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			cols_q <= COLS_RST;
			rows_q <= ROWS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_wdata[0];
				CFG_COLS: cols_q <= cfg_wdata;
				CFG_ROWS: rows_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective active size, clamped to 1..max
	always_comb begin
		eff_cols = (cols_q == '0) ? CFG_W'(1) : cols_q;
		eff_rows = (rows_q == '0) ? CFG_W'(1) : rows_q;
		if (int'(eff_cols) > MAX_COLUMNS) begin
			eff_cols = CFG_W'(MAX_COLUMNS);
		end
		if (int'(eff_rows) > MAX_ROWS) begin
			eff_rows = CFG_W'(MAX_ROWS);
		end
	end

	assign accept = start && uop.idle;
	assign busy   = !uop.idle;

	// command capture with range check
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			err_q  <= ({1'b0, item.cell_row} >= eff_rows) || ({1'b0, item.cell_column} >= eff_cols);
		end
	end

	// clear sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (uop.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// 2-d offset counter, span set by the control word
	assign cnt_last = (r_q == uop.span_last) && (c_q == uop.span_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q <= '0;
			c_q <= '0;
		end else if (uop.ctr_clr) begin
			r_q <= '0;
			c_q <= '0;
		end else if (uop.rd_issue || uop.emit) begin
			if (c_q == uop.span_last) begin
				c_q <= '0;
				r_q <= r_q + 1'b1;
			end else begin
				c_q <= c_q + 1'b1;
			end
		end
	end

	always_comb begin
		flags.start    = start;
		flags.err      = err_q;
		flags.cnt_more = !cnt_last;
		flags.clr_more = (32'(clr_addr_q) != DEPTH - 1);
	end

	// window read address, offsets -2..+2 round the edited cell
	always_comb begin
		rd_row = {2'b00, item_q.cell_row} + {5'b0, r_q} - 8'd2;
		rd_col = {2'b00, item_q.cell_column} + {5'b0, c_q} - 8'd2;
		rd_inb = !rd_row[7] && !rd_col[7] && (rd_row[6:0] < eff_rows) && (rd_col[6:0] < eff_cols);
		mem_raddr = cell_addr(rd_row[6:0], rd_col[6:0]);
	end

	// read pipeline and window capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= uop.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_inb_s1 <= rd_inb;
		rd_r_s1   <= r_q;
		rd_c_s1   <= c_q;
		if (rd_v_s1) begin
			win_q[rd_r_s1][rd_c_s1] <= rd_inb_s1 && mem_rdata[OCC];
		end
	end

	// 3x3 neighbourhood of the cell being emitted
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				nb[a][b] = win_q[r_q + 3'(a)][c_q + 3'(b)];
			end
		end
	end

	// tile code: edge mask or gated blob mask through the table
	always_comb begin
		edge_mask = {nb[2][1], nb[1][2], nb[1][0], nb[0][1]};
		blob_mask[0] = nb[0][1] && nb[1][0] && nb[0][0];
		blob_mask[1] = nb[0][1];
		blob_mask[2] = nb[0][1] && nb[1][2] && nb[0][2];
		blob_mask[3] = nb[1][0];
		blob_mask[4] = nb[1][2];
		blob_mask[5] = nb[2][1] && nb[1][0] && nb[2][0];
		blob_mask[6] = nb[2][1];
		blob_mask[7] = nb[2][1] && nb[1][2] && nb[2][2];
		code = mode_q ? blob_code(blob_mask) : {2'b00, edge_mask};
	end

	// which scan positions give a result, and whether one follows the current one
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				elig[a * 3 + b] = (mode_q || a == 1 || b == 1)
				                  && (win_q[a + 1][b + 1] || (a == 1 && b == 1));
			end
		end
		pos   = {1'b0, r_q} + {r_q, 1'b0} + {1'b0, c_q};
		later = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (4'(k) > pos && elig[k]) begin
				later = 1'b1;
			end
		end
		centre = (r_q == 3'd1) && (c_q == 3'd1);
		occ    = nb[1][1];
		em_row = {2'b00, item_q.cell_row} + {5'b0, r_q} - 8'd1;
		em_col = {2'b00, item_q.cell_column} + {5'b0, c_q} - 8'd1;
	end

	// store write select: clear sweep, edited cell, recomputed neighbour
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		priority if (uop.clr_wr) begin
			mem_we = 1'b1;
		end else if (uop.center_wr) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr({1'b0, item_q.cell_row}, {1'b0, item_q.cell_column});
			mem_wdata = {item_q.action, 6'd0};
		end else if (uop.emit && elig[pos] && occ) begin
			mem_we    = 1'b1;
			mem_waddr = cell_addr(em_row[6:0], em_col[6:0]);
			mem_wdata = {1'b1, code};
		end else begin
			mem_we = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= uop.err_emit || (uop.emit && elig[pos]);
		end
	end

	always_ff @(posedge clk) begin
		if (uop.err_emit) begin
			result_q.status      <= 1'b1;
			result_q.out_column  <= item_q.cell_column;
			result_q.out_row     <= item_q.cell_row;
			result_q.cell_empty  <= 1'b0;
			result_q.tile_code   <= '0;
			result_q.last_result <= 1'b1;
		end else if (uop.emit) begin
			result_q.status      <= 1'b0;
			result_q.out_column  <= em_col[5:0];
			result_q.out_row     <= em_row[5:0];
			result_q.cell_empty  <= centre && !occ;
			result_q.tile_code   <= occ ? code : 6'd0;
			result_q.last_result <= !later;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: sv/bagu_chk.sv
// port-level checker for the autotile grid update block, bound to the top level
`timescale 1ns / 1ps
module bagu_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input bagu_pkg::result_t result
);

	// an accepted command makes the block busy on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after start beat");

	// an error result is the only and therefore last beat of its command
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status |-> result.last_result
		&& !result.cell_empty && result.tile_code == 6'd0)
		else $error("error beat with bad fields");

	// an emptied cell carries no code
	a_empty_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.cell_empty |-> result.tile_code == 6'd0 && !result.status)
		else $error("empty cell beat with nonzero code");

	// an occupied cell carries a code in range; an isolated tile in edge mode has code 0
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.status && !result.cell_empty |->
		result.tile_code <= 6'd47)
		else $error("tile code out of range");

endmodule

bind bitmask_autotile_grid_update bagu_chk u_chk (.*);
